@@ src/slu_pkg.sv @@
package slu_pkg;

	// fixed field widths of the item and result channels
	localparam int DRAW_W  = 16;
	localparam int PROB_W  = 16;
	localparam int INDEX_W = 12;
	localparam int TOTAL_W = 13;

	// read step counter: site itself, then up to three forward neighbors
	localparam int STEP_W = 2;

	// commands from the controller to the datapath
	typedef struct packed {
		logic              latch;         // capture draws of an accepted transaction
		logic              clear_step;    // write one lattice entry as susceptible
		logic              rd_en;         // issue a lattice read
		logic [STEP_W-1:0] rd_step;       // 0 reads the site, j+1 reads neighbor j
		logic              commit;        // write back the site and load the result
		logic              emit_restart;  // load the result of a restart transaction
	} slu_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic clear_last;  // the clear pass is at its last entry
	} slu_stat_t;

endpackage

@@ src/slu_ifs.sv @@
interface slu_item_if;
	logic                       valid;
	logic                       ready;
	logic                       restart;
	logic [slu_pkg::DRAW_W-1:0] draw_first;
	logic [slu_pkg::DRAW_W-1:0] draw_second;

	modport source (output valid, output restart, output draw_first, output draw_second,
		input ready);
	modport sink (input valid, input restart, input draw_first, input draw_second,
		output ready);
endinterface

interface slu_result_if;
	logic                        valid;
	logic                        ready;
	logic [slu_pkg::INDEX_W-1:0] site_index;
	logic                        new_state;
	logic [slu_pkg::TOTAL_W-1:0] susceptible_total;
	logic                        sweep_done;

	modport source (output valid, output site_index, output new_state,
		output susceptible_total, output sweep_done, input ready);
	modport sink (input valid, input site_index, input new_state,
		input susceptible_total, input sweep_done, output ready);
endinterface

@@ src/slu_ram.sv @@
module slu_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/slu_ctrl.sv @@
module slu_ctrl #(
	parameter int DIMENSIONS = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_restart,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output slu_pkg::slu_cmd_t  cmd,
	input  slu_pkg::slu_stat_t stat
);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_READ  = 6'b000100,
		ST_WAIT  = 6'b001000,
		ST_WRITE = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	localparam logic [slu_pkg::STEP_W-1:0] LAST_STEP = slu_pkg::STEP_W'(DIMENSIONS);

	state_t                     state_q, state_nx;
	logic [slu_pkg::STEP_W-1:0] step_q, step_nx;
	logic                       rst_pend_q, rst_pend_nx;
	logic                       out_valid_q;
	logic                       slot_free;
	logic                       in_fire;
	logic                       out_set;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_nx    = state_q;
		step_nx     = step_q;
		rst_pend_nx = rst_pend_q;
		out_set     = 1'b0;
		cmd         = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) begin
					state_nx = rst_pend_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_fire) begin
					cmd.latch = 1'b1;
					step_nx   = '0;
					if (in_restart) begin
						rst_pend_nx = 1'b1;
						state_nx    = ST_CLEAR;
					end else begin
						state_nx = ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_step = step_q;
				if (step_q == LAST_STEP) begin
					state_nx = ST_WAIT;
				end else begin
					step_nx = step_q + 1'b1;
				end
			end
			ST_WAIT: begin
				state_nx = ST_WRITE;
			end
			ST_WRITE: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					out_set    = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					cmd.emit_restart = 1'b1;
					out_set          = 1'b1;
					rst_pend_nx      = 1'b0;
					state_nx         = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			step_q     <= '0;
			rst_pend_q <= 1'b0;
		end else begin
			state_q    <= state_nx;
			step_q     <= step_nx;
			rst_pend_q <= rst_pend_nx;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_set) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	// a result is never loaded over one that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit || cmd.emit_restart) |-> (!out_valid_q || out_ready))
		else $error("result loaded while output slot busy");

	// the clear pass ends after its last entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && stat.clear_last) |=> (state_q != ST_CLEAR))
		else $error("clear pass did not end");

	// a restart transaction always yields its result after the clear pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && stat.clear_last && rst_pend_q) |=> (state_q == ST_EMIT))
		else $error("restart result lost");
`endif

endmodule

@@ src/slu_dp.sv @@
module slu_dp #(
	parameter int LATTICE_SIDE = 16,
	parameter int DIMENSIONS   = 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  slu_pkg::slu_cmd_t            cmd,
	output slu_pkg::slu_stat_t           stat,
	input  logic [slu_pkg::DRAW_W-1:0]   draw_first,
	input  logic [slu_pkg::DRAW_W-1:0]   draw_second,
	input  logic                         cfg_we,
	input  logic [slu_pkg::PROB_W-1:0]   cfg_wdata,
	output logic [slu_pkg::INDEX_W-1:0]  site_index,
	output logic                         new_state,
	output logic [slu_pkg::TOTAL_W-1:0]  susceptible_total,
	output logic                         sweep_done
);

	localparam int N   = LATTICE_SIDE ** DIMENSIONS;
	localparam int AW  = $clog2(N);
	localparam int CW  = $clog2(N + 1);
	localparam int CRW = $clog2(LATTICE_SIDE);
	localparam int PW  = slu_pkg::DRAW_W + CW;
	localparam int HW  = slu_pkg::DRAW_W + 3;

	localparam logic [AW-1:0]  LAST_IDX  = AW'(N - 1);
	localparam logic [CW-1:0]  FULL_CNT  = CW'(N);
	localparam logic [CRW-1:0] COORD_MAX = CRW'(LATTICE_SIDE - 1);

	logic [AW-1:0]                 idx_q;
	logic [CRW-1:0]                coord_q  [DIMENSIONS];
	logic [CRW-1:0]                coord_nx [DIMENSIONS];
	logic [AW-1:0]                 nb_addr  [DIMENSIONS];
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 count_nx;
	logic [AW-1:0]                 clr_addr_q;
	logic [slu_pkg::PROB_W-1:0]    local_prob_q;
	logic [slu_pkg::DRAW_W-1:0]    d1_q;
	logic [slu_pkg::DRAW_W-1:0]    d2_q;
	logic [PW-1:0]                 prod_q;
	logic                          site_q;
	logic [1:0]                    hits_q;
	logic                          rd_en_s1;
	logic [slu_pkg::STEP_W-1:0]    rd_step_s1;
	logic [slu_pkg::INDEX_W-1:0]   site_index_q;
	logic                          new_state_q;
	logic [slu_pkg::TOTAL_W-1:0]   total_q;
	logic                          done_q;

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [AW-1:0] rd_addr;
	logic          ram_wdata;
	logic          ram_rdata;
	logic          recover;
	logic          nb_infect;
	logic          loc_infect;
	logic          upd_state;
	logic          last_site;

	assign stat.clear_last = (clr_addr_q == LAST_IDX);
	assign last_site       = (idx_q == LAST_IDX);

	// forward neighbor of the current site in each dimension, with wrap
	for (genvar j = 0; j < DIMENSIONS; j++) begin : g_nb
		localparam int STRIDE = LATTICE_SIDE ** j;
		assign nb_addr[j] = (coord_q[j] == COORD_MAX) ?
			idx_q - AW'((LATTICE_SIDE - 1) * STRIDE) : idx_q + AW'(STRIDE);
	end

	// read address by step
	always_comb begin
		rd_addr = idx_q;
		for (int j = 0; j < DIMENSIONS; j++) begin
			if (cmd.rd_step == slu_pkg::STEP_W'(j + 1)) begin
				rd_addr = nb_addr[j];
			end
		end
	end

	// lattice port: clear pass, write back, or reads
	always_comb begin
		ram_we    = cmd.clear_step || cmd.commit;
		ram_wdata = cmd.clear_step ? 1'b1 : upd_state;
		if (cmd.clear_step) begin
			ram_addr = clr_addr_q;
		end else if (cmd.commit) begin
			ram_addr = idx_q;
		end else begin
			ram_addr = rd_addr;
		end
	end

	slu_ram #(
		.WIDTH (1),
		.DEPTH (N)
	) u_lattice (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// update decisions
	assign recover    = prod_q < (PW'(count_q) << slu_pkg::DRAW_W);
	assign nb_infect  = (HW'(d1_q) << DIMENSIONS) < (HW'(hits_q) << slu_pkg::DRAW_W);
	assign loc_infect = d2_q < local_prob_q;
	assign upd_state  = site_q ? !(nb_infect || loc_infect) : recover;

	always_comb begin
		count_nx = count_q;
		if (!site_q && recover) begin
			count_nx = count_q + 1'b1;
		end else if (site_q && !upd_state && count_q != '0) begin
			count_nx = count_q - 1'b1;
		end
	end

	// odometer step of the sweep coordinates
	always_comb begin
		logic carry;
		carry = 1'b1;
		for (int j = 0; j < DIMENSIONS; j++) begin
			coord_nx[j] = coord_q[j];
			if (carry) begin
				coord_nx[j] = (coord_q[j] == COORD_MAX) ? '0 : coord_q[j] + 1'b1;
			end
			carry = carry && (coord_q[j] == COORD_MAX);
		end
	end

	// sweep position, susceptible count and clear address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			count_q    <= FULL_CNT;
			clr_addr_q <= '0;
			for (int j = 0; j < DIMENSIONS; j++) begin
				coord_q[j] <= '0;
			end
		end else if (cmd.clear_step) begin
			clr_addr_q <= stat.clear_last ? '0 : clr_addr_q + 1'b1;
			if (stat.clear_last) begin
				idx_q   <= '0;
				count_q <= FULL_CNT;
				for (int j = 0; j < DIMENSIONS; j++) begin
					coord_q[j] <= '0;
				end
			end
		end else if (cmd.commit) begin
			idx_q   <= last_site ? '0 : idx_q + 1'b1;
			count_q <= count_nx;
			for (int j = 0; j < DIMENSIONS; j++) begin
				coord_q[j] <= coord_nx[j];
			end
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_prob_q <= '0;
		end else if (cfg_we) begin
			local_prob_q <= cfg_wdata;
		end
	end

	// read return tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_en_s1   <= 1'b0;
			rd_step_s1 <= '0;
		end else begin
			rd_en_s1   <= cmd.rd_en;
			rd_step_s1 <= cmd.rd_step;
		end
	end

	// draws, site bit, neighbor hits and recovery product
	always_ff @(posedge clk) begin
		prod_q <= PW'(d1_q) * PW'(N);
		if (cmd.latch) begin
			d1_q   <= draw_first;
			d2_q   <= draw_second;
			hits_q <= '0;
		end else if (rd_en_s1) begin
			if (rd_step_s1 == '0) begin
				site_q <= ram_rdata;
			end else if (!ram_rdata) begin
				hits_q <= hits_q + 2'd1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			site_index_q <= slu_pkg::INDEX_W'(idx_q);
			new_state_q  <= upd_state;
			total_q      <= slu_pkg::TOTAL_W'(count_nx);
			done_q       <= last_site;
		end else if (cmd.emit_restart) begin
			site_index_q <= '0;
			new_state_q  <= 1'b1;
			total_q      <= slu_pkg::TOTAL_W'(count_q);
			done_q       <= 1'b0;
		end
	end

	assign site_index        = site_index_q;
	assign new_state         = new_state_q;
	assign susceptible_total = total_q;
	assign sweep_done        = done_q;

`ifndef NO_ASSERTIONS
	// the susceptible count never exceeds the lattice size
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("susceptible count above lattice size");

	// a recovered site raises the count by one
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !site_q && upd_state) |=> (count_q == CW'($past(count_q) + 1'b1)))
		else $error("recovery not counted");

	// the sweep wraps after the last site
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && last_site) |=> (idx_q == '0))
		else $error("sweep did not wrap");
`endif

endmodule

@@ src/sis_lattice_site_update_core.sv @@
// SIS lattice site updater: keeps a periodic lattice of LATTICE_SIDE**DIMENSIONS one-bit
// sites (1 susceptible, 0 infected) in a single-port RAM and updates one site per item, in
// index order, from two 16-bit uniform draws. An update runs from acceptance to result as
// one RAM read for the site and one per forward neighbor, a wait state for the last read
// to return, then the write-back, which waits for a free output slot, all on the one
// RAM port. A restart item refills the lattice with a clearing pass over all LATTICE_SIDE**
// DIMENSIONS entries (4096 by default) and then returns its result; the same pass runs
// after reset, and no item is accepted until it completes. local_prob may be written at
// any time the block is idle. The result sits in an output register, so the next item is
// accepted while a result waits to be taken.
module sis_lattice_site_update_core #(
	parameter int LATTICE_SIDE = 16,
	parameter int DIMENSIONS   = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	slu_item_if.sink                   item,
	slu_result_if.source               result,
	input  logic                       cfg_we,
	input  logic [slu_pkg::PROB_W-1:0] cfg_wdata
);

	slu_pkg::slu_cmd_t  cmd;
	slu_pkg::slu_stat_t stat;

	// sequencing of reads, write-back, clear pass and result handshake
	slu_ctrl #(
		.DIMENSIONS (DIMENSIONS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (item.valid),
		.in_restart (item.restart),
		.in_ready   (item.ready),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.cmd        (cmd),
		.stat       (stat)
	);

	// lattice, counters and update arithmetic
	slu_dp #(
		.LATTICE_SIDE (LATTICE_SIDE),
		.DIMENSIONS   (DIMENSIONS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.draw_first        (item.draw_first),
		.draw_second       (item.draw_second),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.site_index        (result.site_index),
		.new_state         (result.new_state),
		.susceptible_total (result.susceptible_total),
		.sweep_done        (result.sweep_done)
	);

endmodule
